// ===== sv/rsput_pkg.sv =====
// Shared types for the range-sum point-update tree.
`default_nettype none

package rsput_pkg;

  localparam int unsigned SumW = 64;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_DIFF,
    ST_SET_UP,
    ST_Q_LO,
    ST_Q_HI,
    ST_FIN
  } eng_state_e;

  typedef enum logic {
    REQ_SET   = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_e;

  // Finished query result handed from the engine to the output register.
  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] sum;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/rsput_mem.sv =====
// Node-sum memory: one write port, one read port, registered read data.
`default_nettype none

module rsput_mem #(
  parameter int Depth = 2048,
  parameter int AW    = 11
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [rsput_pkg::SumW-1:0] wdata_i,
  input  wire logic [AW-1:0]             raddr_i,
  output      logic [rsput_pkg::SumW-1:0] rdata_o
);

  logic [rsput_pkg::SumW-1:0] mem [Depth];
  logic [rsput_pkg::SumW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/rsput_eng.sv =====
// Sequencer that walks the tree: clearing pass, point update and range query.
`default_nettype none

module rsput_eng #(
  parameter int LeafCount = 1024
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic                       req_type_i,
  input  wire logic [9:0]                 element_index_i,
  input  wire logic [63:0]                new_value_i,
  input  wire logic [9:0]                 first_index_i,
  input  wire logic [9:0]                 last_index_i,
  input  wire logic                       out_free_i,
  output      rsput_pkg::result_t         res_o
);

  localparam int NodeCount = 2 * LeafCount;
  localparam int AW = $clog2(NodeCount);
  localparam int CW = $clog2(NodeCount + 1);
  localparam int XW = (CW > 11) ? CW : 11;
  localparam logic [XW-1:0] LeafX = XW'(LeafCount);
  localparam logic [AW-1:0] LastNode = AW'(NodeCount - 1);
  localparam logic [AW-1:0] RootNode = AW'(1);

  rsput_pkg::eng_state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [AW-1:0] node_q, node_d;
  logic [XW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [63:0]   val_q, val_d, diff_q, diff_d, acc_q, acc_d;
  logic          add_q, add_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata, mem_rdata;

  logic [XW-1:0] idx_x, first_x, last_x, last_c, hi_n;

  rsput_mem #(
    .Depth (NodeCount),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    idx_x   = XW'(element_index_i);
    first_x = XW'(first_index_i);
    last_x  = XW'(last_index_i);
    last_c  = (last_x >= LeafX) ? (LeafX - XW'(1)) : last_x;
    hi_n    = hi_q[0] ? (hi_q - XW'(1)) : hi_q;
  end

  assign in_stall_o = (state_q != rsput_pkg::ST_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    node_d    = node_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    val_d     = val_q;
    diff_d    = diff_q;
    add_d     = 1'b0;
    acc_d     = add_q ? (acc_q + mem_rdata) : acc_q;
    mem_we    = 1'b0;
    mem_waddr = node_q;
    mem_wdata = mem_rdata + diff_q;
    mem_raddr = '0;
    res_o.valid = 1'b0;
    res_o.sum   = acc_q;

    case (state_q)
      rsput_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastNode) begin
          state_d = rsput_pkg::ST_IDLE;
        end
      end
      rsput_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == rsput_pkg::REQ_SET) begin
            // An element past the end of the array leaves the tree alone.
            if (idx_x < LeafX) begin
              lo_d      = idx_x + LeafX;
              node_d    = lo_d[AW-1:0];
              mem_raddr = lo_d[AW-1:0];
              val_d     = new_value_i;
              state_d   = rsput_pkg::ST_SET_DIFF;
            end
          end else begin
            acc_d = '0;
            lo_d  = first_x + LeafX;
            hi_d  = last_c + LeafX + XW'(1);
            // An empty range reports zero without touching the memory.
            if (first_x > last_c) begin
              state_d = rsput_pkg::ST_FIN;
            end else begin
              state_d = rsput_pkg::ST_Q_LO;
            end
          end
        end
      end
      rsput_pkg::ST_SET_DIFF: begin
        diff_d    = val_q - mem_rdata;
        mem_we    = 1'b1;
        mem_waddr = node_q;
        mem_wdata = val_q;
        mem_raddr = node_q >> 1;
        node_d    = node_q >> 1;
        state_d   = rsput_pkg::ST_SET_UP;
      end
      rsput_pkg::ST_SET_UP: begin
        mem_we    = 1'b1;
        mem_waddr = node_q;
        mem_wdata = mem_rdata + diff_q;
        if (node_q == RootNode) begin
          state_d = rsput_pkg::ST_IDLE;
        end else begin
          mem_raddr = node_q >> 1;
          node_d    = node_q >> 1;
        end
      end
      rsput_pkg::ST_Q_LO: begin
        if (lo_q >= hi_q) begin
          state_d = rsput_pkg::ST_FIN;
        end else begin
          if (lo_q[0]) begin
            mem_raddr = lo_q[AW-1:0];
            add_d     = 1'b1;
            lo_d      = lo_q + XW'(1);
          end
          state_d = rsput_pkg::ST_Q_HI;
        end
      end
      rsput_pkg::ST_Q_HI: begin
        if (hi_q[0]) begin
          mem_raddr = hi_n[AW-1:0];
          add_d     = 1'b1;
        end
        lo_d    = lo_q >> 1;
        hi_d    = hi_n >> 1;
        state_d = rsput_pkg::ST_Q_LO;
      end
      rsput_pkg::ST_FIN: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          state_d     = rsput_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rsput_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsput_pkg::ST_CLEAR;
      clr_q   <= '0;
      add_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      add_q   <= add_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    val_q  <= val_d;
    diff_q <= diff_d;
    acc_q  <= acc_d;
  end

endmodule

`default_nettype wire

// ===== sv/range_sum_point_update_tree.sv =====
// Top level of the range-sum point-update tree with its output register.
//
//   Channel  Direction  Handshake                Payload
//   request  in         in_valid_i / in_stall_o  req_type_i, element_index_i,
//                                                new_value_i, first_index_i,
//                                                last_index_i
//   result   out        out_valid_o / out_stall_i range_sum_o
//
// A set request reads the leaf, then every node on the path is read,
// updated and written back while its parent is read, one node at a time
// on the single read port. A query visits each tree level with one step
// for the left border and one for the right border, since the memory has
// one read port. An empty range goes straight to the finish state.
// After reset the memory's 2 * LEAF_COUNT nodes are cleared one by one,
// during which in_stall_o is high. A result waits in the output register
// while the sink stalls, and the engine keeps taking set requests
// meanwhile; a query that finishes while the register is full and stalled
// waits in the engine.
`default_nettype none

module range_sum_point_update_tree #(
  parameter int LEAF_COUNT = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        req_type_i,
  input  wire logic [9:0]  element_index_i,
  input  wire logic signed [63:0] new_value_i,
  input  wire logic [9:0]  first_index_i,
  input  wire logic [9:0]  last_index_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic signed [63:0] range_sum_o
);

  rsput_pkg::result_t res;
  logic               out_valid_q;
  logic [63:0]        range_sum_q;
  logic               out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  rsput_eng #(
    .LeafCount (LEAF_COUNT)
  ) u_eng (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .element_index_i (element_index_i),
    .new_value_i     (new_value_i),
    .first_index_i   (first_index_i),
    .last_index_i    (last_index_i),
    .out_free_i      (out_free),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      range_sum_q <= res.sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = range_sum_q;

endmodule

`default_nettype wire

// ===== sv/rsput_chk.sv =====
// Port-level checker for the range-sum point-update tree and its bind.
`default_nettype none

module rsput_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        req_type_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] range_sum_o
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(range_sum_o))
    else $error("stalled result changed");

  // The memory clearing pass keeps requests out right after reset.
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("request taken during clearing pass");

  // A query that is taken leaves the engine busy, so new requests stall.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i |=> in_stall_o)
    else $error("request taken while a query runs");

  // No result can show up in the cycle right after a request is taken.
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind range_sum_point_update_tree rsput_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .req_type_i  (req_type_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .range_sum_o (range_sum_o)
);

`default_nettype wire
